>>> src/ddfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual deadline frame pacer package
// Shared constants, command and state codes, and unit status type.
// ----------------------------------------------------------------------------
package ddfp_pkg;

	localparam int TIME_BITS_DEF       = 48;
	localparam int COUNT_BITS_DEF      = 32;
	localparam int ALPHA_FRAC_BITS_DEF = 16;

	localparam int PERIOD_BITS   = 24;
	localparam int ELAPSED_BITS  = 16;
	localparam int PROD_BITS     = PERIOD_BITS + ELAPSED_BITS;
	localparam int DELTA_SHIFT   = 8;
	localparam int DELTA_BITS    = PROD_BITS - DELTA_SHIFT;
	localparam int MUL_CNT_BITS  = $clog2(ELAPSED_BITS + 1);
	localparam int CMD_BITS      = 2;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [PROD_BITS-1:0]   ROUND_HALF = PROD_BITS'(1) << (DELTA_SHIFT - 1);
	localparam logic [PERIOD_BITS-1:0] SIM_PERIOD_DEFAULT  = 24'd16639;
	localparam logic [PERIOD_BITS-1:0] PRES_PERIOD_DEFAULT = 24'd16667;

	localparam logic [CFG_IDX_BITS-1:0] REG_SIM_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRES_PERIOD = 2'd1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_POLL      = 2'd0,
		CMD_RESTART   = 2'd1,
		CMD_SIM_DONE  = 2'd2,
		CMD_PRES_DONE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SIM_MUL,
		ST_SIM_ADD,
		ST_SIM_SEL,
		ST_PRES_OVR,
		ST_PRES_DIV,
		ST_PRES_WHOLE,
		ST_PRES_STEP,
		ST_PRES_UPD,
		ST_AL_GAP,
		ST_AL_CMP,
		ST_AL_DIV,
		ST_AL_RND,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage
`default_nettype wire

>>> src/ddfp_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial period multiplier
// Shift-add multiplier, one bit of the elapsed count per cycle.
// ----------------------------------------------------------------------------
module ddfp_mul (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  [ddfp_pkg::ELAPSED_BITS-1:0]     multiplier,
	input  wire  [ddfp_pkg::PERIOD_BITS-1:0]      multiplicand,
	output logic [ddfp_pkg::PROD_BITS-1:0]        product,
	output ddfp_pkg::unit_stat_t                  stat
);

	logic [ddfp_pkg::PROD_BITS-1:0]     prod_q;
	logic [ddfp_pkg::PERIOD_BITS-1:0]   mcand_q;
	logic [ddfp_pkg::MUL_CNT_BITS-1:0]  cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [ddfp_pkg::PERIOD_BITS:0]     sum;

	always_comb begin
		sum = {1'b0, prod_q[ddfp_pkg::PROD_BITS-1:ddfp_pkg::ELAPSED_BITS]}
			+ (prod_q[0] ? {1'b0, mcand_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ddfp_pkg::MUL_CNT_BITS'(ddfp_pkg::ELAPSED_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ddfp_pkg::MUL_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q  <= {{ddfp_pkg::PERIOD_BITS{1'b0}}, multiplier};
			mcand_q <= multiplicand;
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[ddfp_pkg::ELAPSED_BITS-1:1]};
		end
	end

	assign product   = prod_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

>>> src/ddfp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle; quotient bits shift into the dividend register.
// ----------------------------------------------------------------------------
module ddfp_div #(
	parameter int DVD_BITS = ddfp_pkg::TIME_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  [$clog2(DVD_BITS+1)-1:0]         steps,
	input  wire  [DVD_BITS-1:0]                   dividend,
	input  wire  [ddfp_pkg::PERIOD_BITS-1:0]      rem_init,
	input  wire  [ddfp_pkg::PERIOD_BITS-1:0]      divisor,
	output logic [DVD_BITS-1:0]                   quot,
	output logic [ddfp_pkg::PERIOD_BITS-1:0]      rem,
	output ddfp_pkg::unit_stat_t                  stat
);

	localparam int CW = $clog2(DVD_BITS + 1);
	localparam int PB = ddfp_pkg::PERIOD_BITS;

	logic [DVD_BITS-1:0] dvd_q;
	logic [PB-1:0]       rem_q;
	logic [PB-1:0]       dsr_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [PB:0]         trial;
	logic [PB:0]         diff;
	logic                fits;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_BITS-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= rem_init;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[PB-1:0] : trial[PB-1:0];
			dvd_q <= {dvd_q[DVD_BITS-2:0], fits};
		end
	end

	assign quot      = dvd_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

>>> src/dual_deadline_frame_pacer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dual deadline frame pacer
// Paces simulation and presentation deadlines on a tick timebase.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  input   | in_valid / in_ready    | command, now, keep_backlog, periods_used
//  output  | out_valid / out_ready  | simulation_due ... missed_total
//  config  | cfg_we                 | cfg_index, cfg_data
//
// One word is worked on at a time by a sequencer around a serial multiplier
// and a serial divider. Simulation done runs the multiplier, presentation done
// divides the overdue time into missed periods, and poll and restart skip
// both; each then works out alpha, which needs no division when the deadline
// is reached or a full period away. Input is ready again in the cycle after the
// result is loaded; a full output register holds the sequencer until it drains.
// Reset restores the default periods and clears both deadlines and the totals.
// ----------------------------------------------------------------------------
module dual_deadline_frame_pacer #(
	parameter int TIME_BITS       = ddfp_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS      = ddfp_pkg::COUNT_BITS_DEF,
	parameter int ALPHA_FRAC_BITS = ddfp_pkg::ALPHA_FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [ddfp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire  [ddfp_pkg::PERIOD_BITS-1:0]     cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [ddfp_pkg::CMD_BITS-1:0]        command,
	input  wire  [TIME_BITS-1:0]                 now,
	input  wire                                  keep_backlog,
	input  wire  [ddfp_pkg::ELAPSED_BITS-1:0]    periods_used,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 simulation_due,
	output logic                                 presentation_due,
	output logic [ALPHA_FRAC_BITS:0]             alpha,
	output logic [TIME_BITS-1:0]                 earliest_deadline,
	output logic [COUNT_BITS-1:0]                missed_now,
	output logic [COUNT_BITS-1:0]                sim_frame_count,
	output logic [COUNT_BITS-1:0]                present_count,
	output logic [COUNT_BITS-1:0]                missed_total
);

	localparam int TB = TIME_BITS;
	localparam int CB = COUNT_BITS;
	localparam int FB = ALPHA_FRAC_BITS;
	localparam int PB = ddfp_pkg::PERIOD_BITS;
	localparam int CW = $clog2(TIME_BITS + 1);
	localparam int XW = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
	localparam logic [FB:0] ALPHA_ONE = (FB+1)'(1) << FB;

	function automatic logic [TB-1:0] sat_time(input logic [TB:0] s);
		sat_time = s[TB] ? {TB{1'b1}} : s[TB-1:0];
	endfunction

	function automatic logic [CB-1:0] sat_count(input logic [CB:0] s);
		sat_count = s[CB] ? {CB{1'b1}} : s[CB-1:0];
	endfunction

	ddfp_pkg::state_t state_q, state_d;

	logic [PB-1:0]                    sim_period_q;
	logic [PB-1:0]                    pres_period_q;
	ddfp_pkg::cmd_t                   cmd_q;
	logic [TB-1:0]                    now_q;
	logic                             keep_q;
	logic [ddfp_pkg::ELAPSED_BITS-1:0] elapsed_q;

	logic [TB-1:0] sd_q;
	logic [TB-1:0] pd_q;
	logic [CB-1:0] frames_q;
	logic [CB-1:0] presents_q;
	logic [CB-1:0] missed_sum_q;
	logic [CB-1:0] missed_q;
	logic [TB-1:0] work_a_q;
	logic [TB-1:0] work_b_q;
	logic          le_q;
	logic [FB:0]   alpha_q;

	logic          out_valid_q;
	logic          sim_due_q;
	logic          pres_due_q;
	logic [FB:0]   alpha_out_q;
	logic [TB-1:0] earliest_q;
	logic [CB-1:0] missed_out_q;
	logic [CB-1:0] frames_out_q;
	logic [CB-1:0] presents_out_q;
	logic [CB-1:0] missed_sum_out_q;

	logic [PB-1:0] sp;
	logic [PB-1:0] pp;
	logic          out_free;
	logic          alpha_skip;
	logic [TB-1:0] overdue_c;
	logic [ddfp_pkg::PROD_BITS-1:0] prod_round;
	logic [XW-1:0] quot_x;
	logic          rnd;
	logic [FB:0]   q_round;

	logic                           mul_start;
	logic [ddfp_pkg::PROD_BITS-1:0] mul_prod;
	ddfp_pkg::unit_stat_t           mul_stat;

	logic                 div_start;
	logic [CW-1:0]        div_steps;
	logic [TB-1:0]        div_dividend;
	logic [PB-1:0]        div_rem_init;
	logic [TB-1:0]        div_quot;
	logic [PB-1:0]        div_rem;
	ddfp_pkg::unit_stat_t div_stat;

	assign sp = (sim_period_q == '0) ? ddfp_pkg::SIM_PERIOD_DEFAULT : sim_period_q;
	assign pp = (pres_period_q == '0) ? ddfp_pkg::PRES_PERIOD_DEFAULT : pres_period_q;

	assign out_free   = !out_valid_q || out_ready;
	assign alpha_skip = le_q || (work_a_q >= TB'(sp));
	assign overdue_c  = (now_q > pd_q) ? (now_q - pd_q) : '0;
	assign prod_round = mul_prod + ddfp_pkg::ROUND_HALF;
	assign quot_x     = XW'(div_quot);
	assign rnd        = ({1'b0, div_rem} + {2'b00, sp[PB-1:1]}) >= {1'b0, sp};
	assign q_round    = {1'b0, div_quot[FB-1:0]} + (FB+1)'(rnd);

	ddfp_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplier   (elapsed_q),
		.multiplicand (sp),
		.product      (mul_prod),
		.stat         (mul_stat)
	);

	ddfp_div #(
		.DVD_BITS (TIME_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.dividend (div_dividend),
		.rem_init (div_rem_init),
		.divisor  (div_start && state_q == ddfp_pkg::ST_PRES_OVR ? pp : sp),
		.quot     (div_quot),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ddfp_pkg::ST_IDLE: begin
				if (in_valid) state_d = ddfp_pkg::ST_DISPATCH;
			end
			ddfp_pkg::ST_DISPATCH: begin
				unique case (cmd_q)
					ddfp_pkg::CMD_SIM_DONE:  state_d = ddfp_pkg::ST_SIM_MUL;
					ddfp_pkg::CMD_PRES_DONE: state_d = ddfp_pkg::ST_PRES_OVR;
					default:                 state_d = ddfp_pkg::ST_AL_GAP;
				endcase
			end
			ddfp_pkg::ST_SIM_MUL: begin
				if (mul_stat.done) state_d = ddfp_pkg::ST_SIM_ADD;
			end
			ddfp_pkg::ST_SIM_ADD:    state_d = ddfp_pkg::ST_SIM_SEL;
			ddfp_pkg::ST_SIM_SEL:    state_d = ddfp_pkg::ST_AL_GAP;
			ddfp_pkg::ST_PRES_OVR:   state_d = ddfp_pkg::ST_PRES_DIV;
			ddfp_pkg::ST_PRES_DIV: begin
				if (div_stat.done) state_d = ddfp_pkg::ST_PRES_WHOLE;
			end
			ddfp_pkg::ST_PRES_WHOLE: state_d = ddfp_pkg::ST_PRES_STEP;
			ddfp_pkg::ST_PRES_STEP:  state_d = ddfp_pkg::ST_PRES_UPD;
			ddfp_pkg::ST_PRES_UPD:   state_d = ddfp_pkg::ST_AL_GAP;
			ddfp_pkg::ST_AL_GAP:     state_d = ddfp_pkg::ST_AL_CMP;
			ddfp_pkg::ST_AL_CMP: begin
				state_d = alpha_skip ? ddfp_pkg::ST_FIN : ddfp_pkg::ST_AL_DIV;
			end
			ddfp_pkg::ST_AL_DIV: begin
				if (div_stat.done) state_d = ddfp_pkg::ST_AL_RND;
			end
			ddfp_pkg::ST_AL_RND:     state_d = ddfp_pkg::ST_FIN;
			ddfp_pkg::ST_FIN: begin
				if (out_free) state_d = ddfp_pkg::ST_IDLE;
			end
			default:                 state_d = ddfp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ddfp_pkg::ST_IDLE);
		mul_start    = (state_q == ddfp_pkg::ST_DISPATCH) && (cmd_q == ddfp_pkg::CMD_SIM_DONE);
		div_start    = 1'b0;
		div_steps    = CW'(TIME_BITS);
		div_dividend = overdue_c;
		div_rem_init = '0;
		unique case (state_q)
			ddfp_pkg::ST_PRES_OVR: begin
				div_start = 1'b1;
			end
			ddfp_pkg::ST_AL_CMP: begin
				div_start    = !alpha_skip;
				div_steps    = CW'(ALPHA_FRAC_BITS);
				div_dividend = '0;
				div_rem_init = work_a_q[PB-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ddfp_pkg::ST_IDLE;
			sim_period_q  <= ddfp_pkg::SIM_PERIOD_DEFAULT;
			pres_period_q <= ddfp_pkg::PRES_PERIOD_DEFAULT;
			sd_q          <= '0;
			pd_q          <= '0;
			frames_q      <= '0;
			presents_q    <= '0;
			missed_sum_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					ddfp_pkg::REG_SIM_PERIOD:  sim_period_q  <= cfg_data;
					ddfp_pkg::REG_PRES_PERIOD: pres_period_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ddfp_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ddfp_pkg::ST_DISPATCH: begin
					if (cmd_q == ddfp_pkg::CMD_RESTART) begin
						sd_q         <= now_q;
						pd_q         <= now_q;
						frames_q     <= '0;
						presents_q   <= '0;
						missed_sum_q <= '0;
					end
				end
				ddfp_pkg::ST_SIM_SEL: begin
					sd_q     <= (keep_q || now_q <= work_a_q) ? work_a_q : work_b_q;
					frames_q <= sat_count({1'b0, frames_q} + (CB+1)'(1));
				end
				ddfp_pkg::ST_PRES_UPD: begin
					pd_q         <= sat_time({1'b0, pd_q} + {1'b0, work_b_q});
					presents_q   <= sat_count({1'b0, presents_q} + (CB+1)'(1));
					missed_sum_q <= sat_count({1'b0, missed_sum_q} + {1'b0, missed_q});
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q     <= ddfp_pkg::cmd_t'(command);
			now_q     <= now;
			keep_q    <= keep_backlog;
			elapsed_q <= periods_used;
			missed_q  <= '0;
		end
		unique case (state_q)
			ddfp_pkg::ST_SIM_ADD: begin
				work_a_q <= sat_time({1'b0, sd_q}
					+ {1'b0, TB'(prod_round[ddfp_pkg::PROD_BITS-1:ddfp_pkg::DELTA_SHIFT])});
				work_b_q <= sat_time({1'b0, now_q} + {1'b0, TB'(sp)});
			end
			ddfp_pkg::ST_PRES_OVR: begin
				work_a_q <= overdue_c;
			end
			ddfp_pkg::ST_PRES_WHOLE: begin
				work_a_q <= work_a_q - TB'(div_rem);
				missed_q <= (quot_x > XW'({CB{1'b1}})) ? {CB{1'b1}} : quot_x[CB-1:0];
			end
			ddfp_pkg::ST_PRES_STEP: begin
				work_b_q <= sat_time({1'b0, work_a_q} + {1'b0, TB'(pp)});
			end
			ddfp_pkg::ST_AL_GAP: begin
				work_a_q <= sd_q - now_q;
				le_q     <= (sd_q <= now_q);
			end
			ddfp_pkg::ST_AL_CMP: begin
				alpha_q <= le_q ? ALPHA_ONE : '0;
			end
			ddfp_pkg::ST_AL_RND: begin
				alpha_q <= ALPHA_ONE - q_round;
			end
			ddfp_pkg::ST_FIN: begin
				if (out_free) begin
					sim_due_q        <= (now_q >= sd_q);
					pres_due_q       <= (now_q >= pd_q);
					alpha_out_q      <= alpha_q;
					earliest_q       <= (sd_q < pd_q) ? sd_q : pd_q;
					missed_out_q     <= missed_q;
					frames_out_q     <= frames_q;
					presents_out_q   <= presents_q;
					missed_sum_out_q <= missed_sum_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign simulation_due    = sim_due_q;
	assign presentation_due  = pres_due_q;
	assign alpha             = alpha_out_q;
	assign earliest_deadline = earliest_q;
	assign missed_now        = missed_out_q;
	assign sim_frame_count   = frames_out_q;
	assign present_count     = presents_out_q;
	assign missed_total      = missed_sum_out_q;

`ifndef SYNTHESIS
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy && !mul_stat.busy)
		else $error("arithmetic unit busy while accepting a word");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alpha <= ALPHA_ONE)
		else $error("alpha above one");

	a_due_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && simulation_due |-> alpha == ALPHA_ONE)
		else $error("simulation due but alpha below one");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ddfp_pkg::ST_PRES_DIV || state_q == ddfp_pkg::ST_AL_DIV)
		else $error("divider finished outside a wait state");
`endif

endmodule
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Dual deadline frame pacer testbench
// Drives timed events through the valid/ready input channel, predicts every
// report from a local model of both deadlines and the counters, and compares
// each report that leaves the output channel with the oldest prediction.
// Directed tasks cover the power-on state, the period registers and each
// command with its corner cases. Random phases run frame loops under several
// period settings, with idling on both channels, mixed with free noise.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIME_W   = ddfp_pkg::TIME_BITS_DEF;
	localparam int COUNT_W  = ddfp_pkg::COUNT_BITS_DEF;
	localparam int ALPHA_W  = ddfp_pkg::ALPHA_FRAC_BITS_DEF;
	localparam int PERIOD_W = ddfp_pkg::PERIOD_BITS;
	localparam int ELAPSE_W = ddfp_pkg::ELAPSED_BITS;
	localparam int IDX_W    = ddfp_pkg::CFG_IDX_BITS;

	localparam logic [63:0] TIME_MAX  = (64'd1 << TIME_W) - 64'd1;
	localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
	localparam logic [63:0] ALPHA_ONE = 64'd1 << ALPHA_W;
	localparam logic [TIME_W-1:0] NOW_MAX = '1;
	localparam logic [ELAPSE_W-1:0] ONE_PERIOD = 16'd256;

	localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic                  sim_due;
		logic                  pres_due;
		logic [ALPHA_W:0]      alpha;
		logic [TIME_W-1:0]     earliest;
		logic [COUNT_W-1:0]    missed_now;
		logic [COUNT_W-1:0]    sim_frames;
		logic [COUNT_W-1:0]    presents;
		logic [COUNT_W-1:0]    missed_total;
	} pacer_report_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                         cfg_we = 1'b0;
	logic [IDX_W-1:0]             cfg_index = '0;
	logic [PERIOD_W-1:0]          cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [ddfp_pkg::CMD_BITS-1:0] command = '0;
	logic [TIME_W-1:0]            now = '0;
	logic                         keep_backlog = 1'b0;
	logic [ELAPSE_W-1:0]          periods_used = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         simulation_due;
	logic                         presentation_due;
	logic [ALPHA_W:0]             alpha;
	logic [TIME_W-1:0]            earliest_deadline;
	logic [COUNT_W-1:0]           missed_now;
	logic [COUNT_W-1:0]           sim_frame_count;
	logic [COUNT_W-1:0]           present_count;
	logic [COUNT_W-1:0]           missed_total;

	logic [PERIOD_W-1:0]    sim_period_q  = ddfp_pkg::SIM_PERIOD_DEFAULT;
	logic [PERIOD_W-1:0]    pres_period_q = ddfp_pkg::PRES_PERIOD_DEFAULT;
	logic [TIME_W-1:0]      sim_deadline_q  = '0;
	logic [TIME_W-1:0]      pres_deadline_q = '0;
	logic [COUNT_W-1:0]     sim_frames_q = '0;
	logic [COUNT_W-1:0]     presents_q   = '0;
	logic [COUNT_W-1:0]     missed_sum_q = '0;

	pacer_report_t pending_reports[$];
	int error_count = 0;
	int cycle_count = 0;
	bit pacing_on = 1'b1;

	dual_deadline_frame_pacer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.now               (now),
		.keep_backlog      (keep_backlog),
		.periods_used      (periods_used),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.simulation_due    (simulation_due),
		.presentation_due  (presentation_due),
		.alpha             (alpha),
		.earliest_deadline (earliest_deadline),
		.missed_now        (missed_now),
		.sim_frame_count   (sim_frame_count),
		.present_count     (present_count),
		.missed_total      (missed_total)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] clamp_time(input logic [63:0] sum);
		return (sum > TIME_MAX) ? TIME_MAX : sum;
	endfunction

	function automatic logic [63:0] clamp_count(input logic [63:0] sum);
		return (sum > COUNT_MAX) ? COUNT_MAX : sum;
	endfunction

	function automatic pacer_report_t advance_pacer(input ddfp_pkg::cmd_t cmd,
			input logic [TIME_W-1:0] stamp, input logic keep,
			input logic [ELAPSE_W-1:0] elapsed);
		pacer_report_t rep;
		logic [63:0] sp;
		logic [63:0] pp;
		logic [63:0] t;
		logic [63:0] delta;
		logic [63:0] next_dl;
		logic [63:0] overdue;
		logic [63:0] skipped;
		logic [63:0] gap;
		logic [63:0] frac;
		sp = (sim_period_q == 0) ? 64'(ddfp_pkg::SIM_PERIOD_DEFAULT) : 64'(sim_period_q);
		pp = (pres_period_q == 0) ? 64'(ddfp_pkg::PRES_PERIOD_DEFAULT) : 64'(pres_period_q);
		t = 64'(stamp);
		skipped = 0;
		case (cmd)
			ddfp_pkg::CMD_RESTART: begin
				sim_deadline_q = stamp;
				pres_deadline_q = stamp;
				sim_frames_q = '0;
				presents_q = '0;
				missed_sum_q = '0;
			end
			ddfp_pkg::CMD_SIM_DONE: begin
				delta = (64'(elapsed) * sp + 64'd128) >> 8;
				next_dl = clamp_time(64'(sim_deadline_q) + delta);
				sim_deadline_q = (keep || t <= next_dl) ? TIME_W'(next_dl)
					: TIME_W'(clamp_time(t + sp));
				sim_frames_q = COUNT_W'(clamp_count(64'(sim_frames_q) + 64'd1));
			end
			ddfp_pkg::CMD_PRES_DONE: begin
				overdue = (t > 64'(pres_deadline_q)) ? t - 64'(pres_deadline_q) : 64'd0;
				skipped = overdue / pp;
				if (skipped > COUNT_MAX)
					skipped = COUNT_MAX;
				missed_sum_q = COUNT_W'(clamp_count(64'(missed_sum_q) + skipped));
				pres_deadline_q = TIME_W'(clamp_time(64'(pres_deadline_q)
					+ clamp_time(overdue - overdue % pp + pp)));
				presents_q = COUNT_W'(clamp_count(64'(presents_q) + 64'd1));
			end
			default: begin
			end
		endcase
		if (64'(sim_deadline_q) <= t) begin
			frac = ALPHA_ONE;
		end else begin
			gap = 64'(sim_deadline_q) - t;
			if (gap >= sp)
				frac = 0;
			else
				frac = ALPHA_ONE - (gap * ALPHA_ONE + (sp >> 1)) / sp;
		end
		rep.sim_due = (stamp >= sim_deadline_q);
		rep.pres_due = (stamp >= pres_deadline_q);
		rep.alpha = frac[ALPHA_W:0];
		rep.earliest = (sim_deadline_q < pres_deadline_q) ? sim_deadline_q : pres_deadline_q;
		rep.missed_now = COUNT_W'(skipped);
		rep.sim_frames = sim_frames_q;
		rep.presents = presents_q;
		rep.missed_total = missed_sum_q;
		return rep;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : report_checker
		pacer_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("report word arrived with no event outstanding");
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("simulation_due", 64'(want.sim_due), 64'(simulation_due));
				check_field("presentation_due", 64'(want.pres_due), 64'(presentation_due));
				check_field("alpha", 64'(want.alpha), 64'(alpha));
				check_field("earliest_deadline", 64'(want.earliest), 64'(earliest_deadline));
				check_field("missed_now", 64'(want.missed_now), 64'(missed_now));
				check_field("sim_frame_count", 64'(want.sim_frames), 64'(sim_frame_count));
				check_field("present_count", 64'(want.presents), 64'(present_count));
				check_field("missed_total", 64'(want.missed_total), 64'(missed_total));
			end
		end
	end

	always begin : result_sink
		int stall;
		@(posedge clk);
		if (pacing_on && arst_n && $urandom_range(0, 6) == 0) begin
			out_ready <= 1'b0;
			stall = $urandom_range(1, 17);
			repeat (stall) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	task automatic send_word(input ddfp_pkg::cmd_t cmd, input logic [TIME_W-1:0] stamp,
			input logic keep, input logic [ELAPSE_W-1:0] elapsed);
		int gap;
		if (pacing_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		now <= stamp;
		keep_backlog <= keep;
		periods_used <= elapsed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_reports.push_back(advance_pacer(cmd, stamp, keep, elapsed));
	endtask

	task automatic settle_pacer();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_periods(input logic [PERIOD_W-1:0] sim_ticks,
			input logic [PERIOD_W-1:0] pres_ticks);
		cfg_we <= 1'b1;
		cfg_index <= ddfp_pkg::REG_SIM_PERIOD;
		cfg_data <= sim_ticks;
		@(posedge clk);
		cfg_index <= ddfp_pkg::REG_PRES_PERIOD;
		cfg_data <= pres_ticks;
		@(posedge clk);
		cfg_index <= REG_SPARE_A;
		cfg_data <= PERIOD_W'($urandom());
		@(posedge clk);
		cfg_index <= REG_SPARE_B;
		cfg_data <= PERIOD_W'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		sim_period_q = sim_ticks;
		pres_period_q = pres_ticks;
	endtask

	task automatic test_power_on_state();
		send_word(ddfp_pkg::CMD_POLL, '0, 1'b0, '0);
		send_word(ddfp_pkg::CMD_POLL, NOW_MAX, 1'b1, '1);
		settle_pacer();
	endtask

	task automatic test_period_registers();
		set_periods(24'd1, 24'd1);
		send_word(ddfp_pkg::CMD_RESTART, '0, 1'b0, '0);
		send_word(ddfp_pkg::CMD_PRES_DONE, NOW_MAX, 1'b0, '0);
		send_word(ddfp_pkg::CMD_PRES_DONE, NOW_MAX, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, '0, 1'b0, 16'd1);
		settle_pacer();
		set_periods('1, '1);
		send_word(ddfp_pkg::CMD_RESTART, 48'd1000, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, 48'd1000, 1'b1, '1);
		send_word(ddfp_pkg::CMD_PRES_DONE, 48'd1000, 1'b0, '0);
		send_word(ddfp_pkg::CMD_POLL, 48'd1000 + 48'h7FFFFF, 1'b0, '0);
		settle_pacer();
		set_periods('0, '0);
		send_word(ddfp_pkg::CMD_POLL, 48'd20000, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, 48'd20000, 1'b0, ONE_PERIOD);
		settle_pacer();
	endtask

	task automatic test_command_cases();
		set_periods(ddfp_pkg::SIM_PERIOD_DEFAULT, ddfp_pkg::PRES_PERIOD_DEFAULT);
		send_word(ddfp_pkg::CMD_RESTART, 48'd100000, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, 48'd100000, 1'b0, ONE_PERIOD);
		send_word(ddfp_pkg::CMD_POLL, 48'd108000, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, 48'd108000, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, 48'd108000, 1'b0, 16'h0080);
		send_word(ddfp_pkg::CMD_PRES_DONE, 48'd100000, 1'b0, '0);
		send_word(ddfp_pkg::CMD_PRES_DONE, 48'd175001, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, 48'd1000000, 1'b0, ONE_PERIOD);
		send_word(ddfp_pkg::CMD_SIM_DONE, 48'd5000000, 1'b1, ONE_PERIOD);
		send_word(ddfp_pkg::CMD_POLL, '0, 1'b0, '0);
		send_word(ddfp_pkg::CMD_RESTART, NOW_MAX - 48'd10, 1'b0, '0);
		send_word(ddfp_pkg::CMD_SIM_DONE, NOW_MAX - 48'd10, 1'b1, '1);
		send_word(ddfp_pkg::CMD_PRES_DONE, NOW_MAX, 1'b0, '0);
		send_word(ddfp_pkg::CMD_POLL, NOW_MAX, 1'b0, '0);
		settle_pacer();
	endtask

	task automatic test_random_traffic(input int n_items, input bit pacing);
		logic [TIME_W-1:0] clock_now;
		logic [31:0] span;
		int pick;
		int kind;
		clock_now = TIME_W'($urandom());
		span = 32'(pres_period_q);
		pacing_on = pacing;
		send_word(ddfp_pkg::CMD_RESTART, clock_now, 1'b0, '0);
		for (int i = 0; i < n_items; i++) begin
			if (pacing && i % 64 == 63)
				pacing_on = ($urandom_range(0, 3) != 0);
			if (i % 150 == 149)
				settle_pacer();
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				send_word(ddfp_pkg::CMD_RESTART, clock_now, 1'($urandom()),
					16'($urandom()));
			end else if (pick < 10) begin
				clock_now = clock_now + TIME_W'($urandom_range(0, 40)) * span;
				send_word(ddfp_pkg::CMD_PRES_DONE, clock_now, 1'($urandom()),
					16'($urandom()));
			end else if (pick < 85) begin
				clock_now = clock_now + TIME_W'($urandom_range(0, 2 * span));
				kind = $urandom_range(0, 9);
				if (kind < 4)
					send_word(ddfp_pkg::CMD_SIM_DONE, clock_now, 1'($urandom()),
						($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1024))
						: ONE_PERIOD);
				else if (kind < 8)
					send_word(ddfp_pkg::CMD_PRES_DONE, clock_now, 1'($urandom()),
						16'($urandom()));
				else
					send_word(ddfp_pkg::CMD_POLL, clock_now, 1'($urandom()),
						16'($urandom()));
			end else begin
				send_word(ddfp_pkg::cmd_t'($urandom_range(0, 3)),
					TIME_W'({$urandom(), $urandom()}), 1'($urandom()), 16'($urandom()));
			end
		end
		settle_pacer();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_state();
		test_period_registers();
		test_command_cases();

		test_random_traffic(240, 1'b1);
		set_periods(24'd1, 24'd1);
		test_random_traffic(150, 1'b1);
		set_periods(PERIOD_W'($urandom_range(1, 1000)), PERIOD_W'($urandom_range(1, 1000)));
		test_random_traffic(250, 1'b1);
		set_periods('1, '1);
		test_random_traffic(150, 1'b1);
		set_periods(PERIOD_W'($urandom_range(1, 24'hFFFFFF)),
			PERIOD_W'($urandom_range(1, 24'hFFFFFF)));
		test_random_traffic(250, 1'b1);
		set_periods(PERIOD_W'($urandom_range(100, 40000)),
			PERIOD_W'($urandom_range(100, 40000)));
		test_random_traffic(250, 1'b1);
		set_periods(ddfp_pkg::SIM_PERIOD_DEFAULT, ddfp_pkg::PRES_PERIOD_DEFAULT);
		test_random_traffic(160, 1'b0);

		settle_pacer();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
